### src/hbp_pkg.sv
`timescale 1ns / 1ps
package hbp_pkg;

	localparam int FUNC_W           = 2;
	localparam int SYM_W            = 8;
	localparam int WORD_BITS        = 32;
	localparam int LEN_IN_W         = 6;
	localparam int BYTE_BITS        = 8;
	localparam int DEPTH            = 256;
	localparam int ACC_W            = BYTE_BITS + WORD_BITS;
	localparam int CNT_W            = $clog2(ACC_W);
	localparam int MAX_CODE_LEN_DEF = 32;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_ENCODE = 2'd1,
		FUNC_FINISH = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BUILD,
		ST_EMIT,
		ST_FIN_DATA,
		ST_FIN_CNT
	} state_t;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_ACC,
		OUT_CNT,
		OUT_EIGHT
	} out_sel_t;

	typedef struct packed {
		logic     wr_en;
		logic     rd_en;
		logic     build;
		logic     shift;
		logic     clear;
		out_sel_t out_sel;
		logic     out_last;
	} hbp_cmd_t;

	typedef struct packed {
		logic has_byte;
		logic last_byte;
		logic cnt_zero;
		logic slot_free;
	} hbp_stat_t;

endpackage

### src/hbp_in_if.sv
`timescale 1ns / 1ps
interface hbp_in_if;
	logic                          valid;
	logic                          ready;
	logic [hbp_pkg::FUNC_W-1:0]    func;
	logic [hbp_pkg::SYM_W-1:0]     symbol;
	logic [hbp_pkg::WORD_BITS-1:0] code_bits;
	logic [hbp_pkg::LEN_IN_W-1:0]  code_length;

	modport source (output valid, func, symbol, code_bits, code_length, input ready);
	modport sink (input valid, func, symbol, code_bits, code_length, output ready);
endinterface

### src/hbp_out_if.sv
`timescale 1ns / 1ps
interface hbp_out_if;
	logic                          valid;
	logic                          ready;
	logic [hbp_pkg::BYTE_BITS-1:0] out_byte;
	logic                          last_of_run;

	modport source (output valid, out_byte, last_of_run, input ready);
	modport sink (input valid, out_byte, last_of_run, output ready);
endinterface

### src/hbp_datapath.sv
`timescale 1ns / 1ps
module hbp_datapath #(
	parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [hbp_pkg::SYM_W-1:0]     symbol,
	input  logic [hbp_pkg::WORD_BITS-1:0] code_bits,
	input  logic [hbp_pkg::LEN_IN_W-1:0]  code_length,
	input  hbp_pkg::hbp_cmd_t             cmd,
	output hbp_pkg::hbp_stat_t            stat,
	hbp_out_if.source                     out_item
);
	import hbp_pkg::*;

	localparam int LEN_LIM = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
	localparam int LEN_W   = $clog2(LEN_LIM + 1);
	localparam int ENT_W   = WORD_BITS + LEN_W;

	logic [ENT_W-1:0]     mem [DEPTH];
	logic [ENT_W-1:0]     rd_q;
	logic [LEN_W-1:0]     ld_len;
	logic [WORD_BITS-1:0] rd_code;
	logic [CNT_W-1:0]     rd_len;
	logic [WORD_BITS-1:0] code_al;
	logic [ACC_W-1:0]     merged;
	logic [ACC_W-1:0]     acc_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 valid_q;
	logic [BYTE_BITS-1:0] byte_q;
	logic                 last_q;

	// saturate code length on load
	always_comb begin
		if (code_length > LEN_IN_W'(LEN_LIM)) begin
			ld_len = LEN_W'(LEN_LIM);
		end else begin
			ld_len = code_length[LEN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[symbol] <= {code_bits, ld_len};
		end
		if (cmd.rd_en) begin
			rd_q <= mem[symbol];
		end
	end

	// code left aligned, bits beyond the length cleared
	assign rd_code = rd_q[ENT_W-1:LEN_W];
	assign rd_len  = CNT_W'(rd_q[LEN_W-1:0]);
	assign code_al = rd_code << (CNT_W'(WORD_BITS) - rd_len);
	assign merged  = {acc_q[ACC_W-1 -: BYTE_BITS], {WORD_BITS{1'b0}}}
		| ({code_al, {BYTE_BITS{1'b0}}} >> cnt_q[2:0]);

	// accumulator is left aligned: valid bits at the top, zeros below
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (cmd.clear) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (cmd.build) begin
			acc_q <= merged;
			cnt_q <= cnt_q + rd_len;
		end else if (cmd.shift) begin
			acc_q <= acc_q << BYTE_BITS;
			cnt_q <= cnt_q - CNT_W'(BYTE_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_sel != OUT_NONE) begin
			valid_q <= 1'b1;
		end else if (out_item.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.out_sel)
			OUT_ACC: begin
				byte_q <= acc_q[ACC_W-1 -: BYTE_BITS];
				last_q <= cmd.out_last;
			end
			OUT_CNT: begin
				byte_q <= BYTE_BITS'(cnt_q);
				last_q <= cmd.out_last;
			end
			OUT_EIGHT: begin
				byte_q <= BYTE_BITS'(BYTE_BITS);
				last_q <= cmd.out_last;
			end
			default: begin
				byte_q <= byte_q;
				last_q <= last_q;
			end
		endcase
	end

	assign out_item.valid       = valid_q;
	assign out_item.out_byte    = byte_q;
	assign out_item.last_of_run = last_q;

	assign stat.has_byte  = (cnt_q >= CNT_W'(BYTE_BITS));
	assign stat.last_byte = (cnt_q < CNT_W'(2 * BYTE_BITS));
	assign stat.cnt_zero  = (cnt_q == '0);
	assign stat.slot_free = !valid_q || out_item.ready;

endmodule

### src/hbp_ctrl.sv
`timescale 1ns / 1ps
module hbp_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [hbp_pkg::FUNC_W-1:0] func,
	input  hbp_pkg::hbp_stat_t         stat,
	output logic                       in_ready,
	output hbp_pkg::hbp_cmd_t          cmd
);
	import hbp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.out_sel  = OUT_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (func_t'(func))
						FUNC_LOAD: begin
							cmd.wr_en = 1'b1;
						end
						FUNC_ENCODE: begin
							cmd.rd_en = 1'b1;
							state_d   = ST_BUILD;
						end
						FUNC_FINISH: begin
							state_d = ST_FIN_DATA;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_BUILD: begin
				cmd.build = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (!stat.has_byte) begin
					state_d = ST_IDLE;
				end else if (stat.slot_free) begin
					cmd.out_sel  = OUT_ACC;
					cmd.out_last = stat.last_byte;
					cmd.shift    = 1'b1;
					if (stat.last_byte) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_FIN_DATA: begin
				if (stat.slot_free) begin
					if (stat.cnt_zero) begin
						cmd.out_sel  = OUT_EIGHT;
						cmd.out_last = 1'b1;
						cmd.clear    = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						cmd.out_sel = OUT_ACC;
						state_d     = ST_FIN_CNT;
					end
				end
			end
			ST_FIN_CNT: begin
				if (stat.slot_free) begin
					cmd.out_sel  = OUT_CNT;
					cmd.out_last = 1'b1;
					cmd.clear    = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### src/huffman_encode_bit_packer_unit.sv
`timescale 1ns / 1ps
// Huffman byte encoder with bit packer. Load beats (func 0) write a code word and length
// into a 256-entry table; encode beats (func 1) read the table, append the code MSB first
// to a left-aligned accumulator and send each completed byte; finish beats (func 2) send
// the zero-padded last byte plus a valid-bit count, or a single 8 when nothing is pending,
// then clear the accumulator. An encode beat reads the table, merges the code into the
// accumulator, then sends its completed bytes in order. The input is taken only in the
// idle state, and output backpressure holds the byte sends until the receiver is ready.
module huffman_encode_bit_packer_unit #(
	parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	hbp_in_if.sink    in_item,
	hbp_out_if.source out_item
);
	import hbp_pkg::*;

	hbp_cmd_t  cmd;
	hbp_stat_t stat;
	logic      ready;

	hbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_item.valid),
		.func     (in_item.func),
		.stat     (stat),
		.in_ready (ready),
		.cmd      (cmd)
	);

	hbp_datapath #(
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.symbol      (in_item.symbol),
		.code_bits   (in_item.code_bits),
		.code_length (in_item.code_length),
		.cmd         (cmd),
		.stat        (stat),
		.out_item    (out_item)
	);

	assign in_item.ready = ready;

endmodule

### dv/hbp_encode_checker.sv
`timescale 1ns / 1ps
module hbp_encode_checker
	import hbp_pkg::*;
#(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	hbp_in_if    in_mon,
	hbp_out_if   out_mon,
	output int   fail_count,
	output int   bytes_owed
);

	localparam int          LEN_CAP    = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
	localparam logic [7:0]  EMPTY_MARK = 8'd8;

	typedef struct packed {
		logic [7:0] byte_val;
		logic       last;
	} packed_byte_t;

	packed_byte_t owed_q[$];
	logic [31:0]  code_word [DEPTH];
	logic [5:0]   code_len [DEPTH];
	logic [6:0]   pend_bits = '0;
	logic [2:0]   pend_cnt  = '0;
	int           fails     = 0;
	int           owed_cnt  = 0;

	assign fail_count = fails;
	assign bytes_owed = owed_cnt;

	function automatic void owe_byte(input logic [7:0] v, input logic last);
		packed_byte_t pb;
		pb.byte_val = v;
		pb.last     = last;
		owed_q.push_back(pb);
		owed_cnt++;
	endfunction

	task automatic absorb_beat(input logic [1:0] f, input logic [7:0] s,
			input logic [31:0] bits, input logic [5:0] len);
		logic [63:0] acc;
		int          ln;
		int          total;
		int          n_out;
		case (func_t'(f))
			FUNC_LOAD: begin
				code_word[s] = bits;
				code_len[s]  = (int'(len) > LEN_CAP) ? 6'(LEN_CAP) : len;
			end
			FUNC_ENCODE: begin
				ln    = int'(code_len[s]);
				acc   = ({57'd0, pend_bits} << ln)
					| ({32'd0, code_word[s]} & ((64'd1 << ln) - 64'd1));
				total = int'(pend_cnt) + ln;
				n_out = total / 8;
				for (int k = 0; k < n_out; k++)
					owe_byte(8'(acc >> (total - 8 * (k + 1))), k == n_out - 1);
				pend_cnt  = 3'(total % 8);
				pend_bits = 7'(acc & ((64'd1 << pend_cnt) - 64'd1));
			end
			FUNC_FINISH: begin
				if (pend_cnt != 0) begin
					owe_byte(8'({1'b0, pend_bits} << (8 - pend_cnt)), 1'b0);
					owe_byte(8'(pend_cnt), 1'b1);
				end else begin
					owe_byte(EMPTY_MARK, 1'b1);
				end
				pend_bits = '0;
				pend_cnt  = '0;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		packed_byte_t pb;
		if (!arst_n) begin
			pend_bits = '0;
			pend_cnt  = '0;
			owed_q.delete();
			owed_cnt  = 0;
		end else begin
			if (in_mon.valid && in_mon.ready)
				absorb_beat(in_mon.func, in_mon.symbol, in_mon.code_bits, in_mon.code_length);
			if (out_mon.valid && out_mon.ready) begin
				if (owed_q.size() == 0) begin
					$error("unexpected beat: out_byte=%02h last_of_run=%0b",
						out_mon.out_byte, out_mon.last_of_run);
					fails++;
				end else begin
					pb = owed_q.pop_front();
					owed_cnt--;
					if (out_mon.out_byte !== pb.byte_val) begin
						$error("out_byte: expected %02h actual %02h", pb.byte_val, out_mon.out_byte);
						fails++;
					end
					if (out_mon.last_of_run !== pb.last) begin
						$error("last_of_run: expected %0b actual %0b", pb.last,
							out_mon.last_of_run);
						fails++;
					end
				end
			end
		end
	end

endmodule

### dv/tb_huffman_encode_bit_packer_unit.sv
`timescale 1ns / 1ps
module tb_huffman_encode_bit_packer_unit;
	import hbp_pkg::*;

	localparam logic [1:0] FUNC_UNUSED  = 2'd3;
	localparam int         RAND_ITEMS   = 300;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         IDLE_LIMIT   = 4000;
	localparam int         DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n = 1'b0;
	logic hold_req;
	bit   tx_calm;
	int   fail_count;
	int   bytes_owed;
	int   idle_cycles = 0;

	bit         sym_loaded [DEPTH];
	logic [7:0] loaded_q[$];

	hbp_in_if  in_item ();
	hbp_out_if out_item ();

	huffman_encode_bit_packer_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.out_item (out_item)
	);

	hbp_encode_checker CHK (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_item),
		.out_mon    (out_item),
		.fail_count (fail_count),
		.bytes_owed (bytes_owed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
	endfunction

	task automatic send_beat(input logic [1:0] f, input logic [7:0] s,
			input logic [31:0] bits, input logic [5:0] len);
		int gap;
		gap = (!tx_calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			in_item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_item.valid       <= 1'b1;
		in_item.func        <= f;
		in_item.symbol      <= s;
		in_item.code_bits   <= bits;
		in_item.code_length <= len;
		do @(posedge clk); while (!in_item.ready);
	endtask

	task automatic load_entry(input logic [7:0] s, input logic [31:0] bits,
			input logic [5:0] len);
		send_beat(FUNC_LOAD, s, bits, len);
		if (!sym_loaded[s]) begin
			sym_loaded[s] = 1'b1;
			loaded_q.push_back(s);
		end
	endtask

	task automatic encode_sym(input logic [7:0] s);
		send_beat(FUNC_ENCODE, s, $urandom(), 6'($urandom_range(0, 63)));
	endtask

	task automatic finish_stream();
		send_beat(FUNC_FINISH, 8'($urandom_range(0, 255)), $urandom(),
			6'($urandom_range(0, 63)));
	endtask

	function automatic logic [5:0] pick_len();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 6'd0;
		else if (r < 3)
			return 6'($urandom_range(33, 63));
		else if (r < 6)
			return 6'($urandom_range(17, 32));
		return 6'($urandom_range(1, 12));
	endfunction

	// receiver pacing, with one long hold-off on request
	initial begin : rx_pacing
		int gap_left;
		int hold_left;
		bit calm;
		bit hold_done;
		gap_left  = 0;
		hold_left = 0;
		calm      = 1'b0;
		hold_done = 1'b0;
		out_item.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				calm = !calm;
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_item.ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				out_item.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				gap_left = pick_gap() - 1;
				out_item.ready <= 1'b0;
			end else begin
				out_item.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_item.valid && in_item.ready) || (out_item.valid && out_item.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		int   sent;
		int   r;
		logic [1:0] f;
		in_item.valid       <= 1'b0;
		in_item.func        <= FUNC_LOAD;
		in_item.symbol      <= '0;
		in_item.code_bits   <= '0;
		in_item.code_length <= '0;
		hold_req            <= 1'b0;
		tx_calm = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty finish, extreme entries, saturation, zero length
		finish_stream();
		load_entry(8'h00, 32'hFFFF_FFFE, 6'd1);
		load_entry(8'hFF, 32'hFFFF_FFFF, 6'd32);
		load_entry(8'h55, 32'hA5A5_A5A5, 6'd63);
		load_entry(8'hAA, 32'h0000_FFFF, 6'd0);
		load_entry(8'h01, 32'h0000_005A, 6'd7);
		load_entry(8'h02, 32'h0000_00C3, 6'd8);
		load_entry(8'h03, 32'h1234_5678, 6'd33);
		encode_sym(8'hFF);
		encode_sym(8'h00);
		encode_sym(8'hFF);
		encode_sym(8'h55);
		encode_sym(8'h01);
		encode_sym(8'hAA);
		finish_stream();
		encode_sym(8'h01);
		finish_stream();
		send_beat(FUNC_UNUSED, 8'hC3, 32'hDEAD_BEEF, 6'd5);
		encode_sym(8'h02);
		encode_sym(8'h00);
		finish_stream();
		encode_sym(8'h03);
		finish_stream();

		// random: back-to-back burst against a stalled receiver first
		hold_req <= 1'b1;
		tx_calm = 1'b1;
		sent = 0;
		while (sent < RAND_ITEMS) begin
			if (sent == 40)
				tx_calm = 1'b0;
			else if (sent > 40 && $urandom_range(0, 29) == 0)
				tx_calm = !tx_calm;
			r = $urandom_range(0, 99);
			if (r < 3)
				f = FUNC_UNUSED;
			else if (r < 15)
				f = FUNC_LOAD;
			else if (r < 25)
				f = FUNC_FINISH;
			else
				f = FUNC_ENCODE;
			case (f)
				FUNC_LOAD:
					load_entry(8'($urandom_range(0, 255)), $urandom(), pick_len());
				FUNC_ENCODE:
					encode_sym(loaded_q[$urandom_range(0, loaded_q.size() - 1)]);
				FUNC_FINISH:
					finish_stream();
				default:
					send_beat(FUNC_UNUSED, 8'($urandom_range(0, 255)), $urandom(),
						6'($urandom_range(0, 63)));
			endcase
			if (f != FUNC_UNUSED)
				sent++;
		end
		finish_stream();
		in_item.valid <= 1'b0;

		@(posedge clk);
		while (bytes_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
